// ===== design/encoder_bank_with_button_debounce_defines.svh =====
// Assertion macros for the encoder bank with button debounce.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ENCODER_BANK_WITH_BUTTON_DEBOUNCE_DEFINES_SVH
`define ENCODER_BANK_WITH_BUTTON_DEBOUNCE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EBBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define EBBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ebbd_pkg.sv =====
// Shared constants, register codes and control types for the encoder bank.
// No dependencies; every other file but the assertion macro header imports it.
`timescale 1ns / 1ps

package ebbd_pkg;

   localparam int DEF_NUM_ENCODERS  = 3;
   localparam int DEF_COUNT_WIDTH   = 16;

   // lines per encoder in the sampled vector: A, B, switch
   localparam int LINES_PER_ENC     = 3;
   localparam int LINE_A            = 0;
   localparam int LINE_B            = 1;
   localparam int LINE_SW           = 2;

   localparam int MS_WIDTH          = 8;
   localparam int STEP_WIDTH        = 8;
   localparam int PERIOD_WIDTH      = 16;
   localparam int COUNT_VALUE_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH   = 3;
   localparam int CSR_DATA_WIDTH    = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_MS   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VF_THRESHOLD  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VF_STEP       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_F_THRESHOLD   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_F_STEP        = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INVERT_MASK   = 3'd6;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [MS_WIDTH-1:0]     RST_DEBOUNCE_MS  = 8'd20;
   localparam logic [PERIOD_WIDTH-1:0] RST_LONG_PRESS   = 16'd50;
   localparam logic [MS_WIDTH-1:0]     RST_VF_THRESHOLD = 8'd10;
   localparam logic [STEP_WIDTH-1:0]   RST_VF_STEP      = 8'd10;
   localparam logic [MS_WIDTH-1:0]     RST_F_THRESHOLD  = 8'd30;
   localparam logic [STEP_WIDTH-1:0]   RST_F_STEP       = 8'd4;

   typedef logic [MS_WIDTH-1:0] ms_type;

   // per-request strobes from the input stage to the state blocks
   typedef struct packed {
      logic tick;
      logic rd;
      logic clear;
   } ebbd_ctl_type;

   typedef struct packed {
      logic [MS_WIDTH-1:0]   vf_thr;
      logic [STEP_WIDTH-1:0] vf_step;
      logic [MS_WIDTH-1:0]   f_thr;
      logic [STEP_WIDTH-1:0] f_step;
   } ebbd_accel_type;

endpackage

// ===== design/ebbd_if.sv =====
// Request and result channel interfaces (valid/ready with payload).
// Depends on ebbd_pkg.
`timescale 1ns / 1ps

interface ebbd_req_if import ebbd_pkg::*; #(
   parameter int NUM_ENCODERS = DEF_NUM_ENCODERS,
   parameter int SEL_WIDTH    = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1
) ();
   logic                                  valid;
   logic                                  ready;
   logic                                  req_type;
   logic [LINES_PER_ENC*NUM_ENCODERS-1:0] line_vector;
   logic [MS_WIDTH-1:0]                   elapsed_ms;
   logic [SEL_WIDTH-1:0]                  encoder_select;
   logic                                  clear_count;

   modport source (output valid, req_type, line_vector, elapsed_ms, encoder_select,
                   clear_count, input ready);
   modport sink   (input valid, req_type, line_vector, elapsed_ms, encoder_select,
                   clear_count, output ready);
endinterface

interface ebbd_rsp_if import ebbd_pkg::*; #(
   parameter int NUM_ENCODERS = DEF_NUM_ENCODERS
) ();
   logic                                valid;
   logic                                ready;
   logic signed [COUNT_VALUE_WIDTH-1:0] count_value;
   logic [NUM_ENCODERS-1:0]             enc_changed;
   logic [NUM_ENCODERS-1:0]             step_up;
   logic [NUM_ENCODERS-1:0]             step_down;
   logic [NUM_ENCODERS-1:0]             step_accel;
   logic [NUM_ENCODERS-1:0]             btn_current;
   logic [NUM_ENCODERS-1:0]             btn_toggled;
   logic [NUM_ENCODERS-1:0]             btn_activated;
   logic [NUM_ENCODERS-1:0]             btn_short;
   logic [NUM_ENCODERS-1:0]             btn_long;
   logic [NUM_ENCODERS-1:0]             btn_changed;

   modport source (output valid, count_value, enc_changed, step_up, step_down, step_accel,
                   btn_current, btn_toggled, btn_activated, btn_short, btn_long,
                   btn_changed, input ready);
   modport sink   (input valid, count_value, enc_changed, step_up, step_down, step_accel,
                   btn_current, btn_toggled, btn_activated, btn_short, btn_long,
                   btn_changed, output ready);
endinterface

// ===== design/ebbd_encoders.sv =====
// Quadrature edge detection, accelerated step and count registers.
// Depends on ebbd_pkg.
`timescale 1ns / 1ps

module ebbd_encoders import ebbd_pkg::*; #(
   parameter int NUM_ENCODERS = DEF_NUM_ENCODERS,
   parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
   parameter int SEL_WIDTH    = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ebbd_ctl_type            ctl,
   input  logic [NUM_ENCODERS-1:0] a_lines,
   input  logic [NUM_ENCODERS-1:0] b_lines,
   input  ms_type                  elapsed_ms,
   input  logic [SEL_WIDTH-1:0]    encoder_select,
   input  ebbd_accel_type          accel,
   input  logic [NUM_ENCODERS-1:0] invert_mask,
   output logic [COUNT_WIDTH-1:0]  count_out,
   output logic [NUM_ENCODERS-1:0] enc_changed,
   output logic [NUM_ENCODERS-1:0] step_up,
   output logic [NUM_ENCODERS-1:0] step_down,
   output logic [NUM_ENCODERS-1:0] step_accel
);

   logic [NUM_ENCODERS-1:0] prev_a_ff, prev_a_in;
   logic [NUM_ENCODERS-1:0] changed_ff, changed_in;
   logic [COUNT_WIDTH-1:0]  counts_ff [NUM_ENCODERS];
   logic [COUNT_WIDTH-1:0]  counts_in [NUM_ENCODERS];
   logic [NUM_ENCODERS-1:0] act;
   logic [STEP_WIDTH-1:0]   step;
   logic [COUNT_WIDTH-1:0]  step_ext;
   logic                    sel_ok;

   always_comb begin
      step = (elapsed_ms < accel.vf_thr) ? accel.vf_step :
             (elapsed_ms < accel.f_thr)  ? accel.f_step  : STEP_WIDTH'(1);
      step_ext = COUNT_WIDTH'(step);
      // active edge: A changed and now sits at the active level
      act = (a_lines ^ invert_mask) & (a_lines ^ prev_a_ff);
      sel_ok = (int'(encoder_select) < NUM_ENCODERS);

      prev_a_in   = prev_a_ff;
      changed_in  = changed_ff;
      counts_in   = counts_ff;
      count_out   = '0;
      enc_changed = changed_ff;
      step_up     = '0;
      step_down   = '0;
      step_accel  = '0;

      if (ctl.tick) begin
         step_up   = act & ~b_lines;
         step_down = act & b_lines;
         prev_a_in = a_lines;
         if (step > STEP_WIDTH'(1)) begin
            step_accel = step_up | step_down;
         end
         for (int i = 0; i < NUM_ENCODERS; i++) begin
            if (step_up[i]) begin
               counts_in[i] = counts_ff[i] + step_ext;
            end else if (step_down[i]) begin
               counts_in[i] = counts_ff[i] - step_ext;
            end
         end
         changed_in  = changed_ff | step_up | step_down;
         enc_changed = changed_in;
      end else if (ctl.rd && sel_ok) begin
         count_out = counts_ff[encoder_select];
         if (ctl.clear) begin
            counts_in[encoder_select] = '0;
         end
         changed_in[encoder_select] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff  <= '0;
         changed_ff <= '0;
         for (int i = 0; i < NUM_ENCODERS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         prev_a_ff  <= prev_a_in;
         changed_ff <= changed_in;
         counts_ff  <= counts_in;
      end
   end

endmodule

// ===== design/ebbd_buttons.sv =====
// Switch debounce timer, long-press timer and button status flags.
// Depends on ebbd_pkg.
`timescale 1ns / 1ps

module ebbd_buttons import ebbd_pkg::*; #(
   parameter int NUM_ENCODERS = DEF_NUM_ENCODERS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ebbd_ctl_type            ctl,
   input  logic [NUM_ENCODERS-1:0] sw_lines,
   input  ms_type                  elapsed_ms,
   input  ms_type                  debounce_ms,
   input  logic [PERIOD_WIDTH-1:0] long_press_periods,
   output logic [NUM_ENCODERS-1:0] btn_current,
   output logic [NUM_ENCODERS-1:0] btn_toggled,
   output logic [NUM_ENCODERS-1:0] btn_activated,
   output logic [NUM_ENCODERS-1:0] btn_short,
   output logic [NUM_ENCODERS-1:0] btn_long,
   output logic [NUM_ENCODERS-1:0] btn_changed
);

   logic [NUM_ENCODERS-1:0] prev_raw_ff, prev_raw_in;
   logic [NUM_ENCODERS-1:0] stable_ff, stable_in;
   logic [NUM_ENCODERS-1:0] pattern_ff, pattern_in;
   logic [NUM_ENCODERS-1:0] changed_ff, changed_in;
   logic [NUM_ENCODERS-1:0] activated_ff, activated_in;
   logic [NUM_ENCODERS-1:0] toggled_ff, toggled_in;
   logic [NUM_ENCODERS-1:0] short_ff, short_in;
   logic [NUM_ENCODERS-1:0] long_ff, long_in;
   logic [MS_WIDTH-1:0]     db_timer_ff, db_timer_in;
   logic [PERIOD_WIDTH-1:0] lp_timer_ff, lp_timer_in;
   logic [MS_WIDTH-1:0]     db_next;
   logic [PERIOD_WIDTH-1:0] lp_dec;
   logic [NUM_ENCODERS-1:0] dif, rise, fall;

   always_comb begin
      prev_raw_in  = prev_raw_ff;
      stable_in    = stable_ff;
      pattern_in   = pattern_ff;
      changed_in   = changed_ff;
      activated_in = activated_ff;
      toggled_in   = toggled_ff;
      short_in     = short_ff;
      long_in      = long_ff;
      db_timer_in  = db_timer_ff;
      lp_timer_in  = lp_timer_ff;
      db_next      = db_timer_ff;
      lp_dec       = lp_timer_ff - PERIOD_WIDTH'(1);
      dif          = sw_lines ^ stable_ff;
      rise         = dif & sw_lines;
      fall         = dif & stable_ff;

      if (ctl.tick) begin
         if (sw_lines == prev_raw_ff) begin
            db_next = (db_timer_ff > elapsed_ms) ? db_timer_ff - elapsed_ms : '0;
         end else begin
            // raw lines moved: restart the debounce window
            db_next     = debounce_ms;
            prev_raw_in = sw_lines;
         end

         if (db_next == '0) begin
            db_timer_in  = debounce_ms;
            changed_in   = changed_ff | dif;
            activated_in = (activated_ff | rise) & ~fall;
            toggled_in   = toggled_ff ^ rise;
            stable_in    = sw_lines;
            if (dif != '0) begin
               lp_timer_in = long_press_periods;
               short_in    = (short_ff | (fall & ~pattern_ff)) & ~rise;
               long_in     = long_ff & ~fall;
               pattern_in  = pattern_ff & ~fall;
            end else if (lp_timer_ff != '0) begin
               lp_timer_in = lp_dec;
               if (lp_dec == '0) begin
                  pattern_in = sw_lines;
                  long_in    = long_ff | sw_lines;
                  short_in   = short_ff & ~sw_lines;
               end
            end
         end else begin
            db_timer_in = db_next;
         end
      end

      btn_current   = stable_in;
      btn_toggled   = toggled_in;
      btn_activated = activated_in;
      btn_short     = short_in;
      btn_long      = long_in;
      btn_changed   = ctl.rd ? changed_ff : changed_in;
      // a read consumes the change flags
      if (ctl.rd) begin
         changed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff  <= '0;
         stable_ff    <= '0;
         pattern_ff   <= '0;
         changed_ff   <= '0;
         activated_ff <= '0;
         toggled_ff   <= '0;
         short_ff     <= '0;
         long_ff      <= '0;
         db_timer_ff  <= RST_DEBOUNCE_MS;
         lp_timer_ff  <= RST_LONG_PRESS;
      end else begin
         prev_raw_ff  <= prev_raw_in;
         stable_ff    <= stable_in;
         pattern_ff   <= pattern_in;
         changed_ff   <= changed_in;
         activated_ff <= activated_in;
         toggled_ff   <= toggled_in;
         short_ff     <= short_in;
         long_ff      <= long_in;
         db_timer_ff  <= db_timer_in;
         lp_timer_ff  <= lp_timer_in;
      end
   end

endmodule

// ===== design/encoder_bank_with_button_debounce.sv =====
// Channel     | Dir | Handshake        | Payload
// req_chan    | in  | valid/ready      | req_type, line_vector, elapsed_ms, encoder_select,
//             |     |                  | clear_count
// rsp_chan    | out | valid/ready      | count_value, enc_changed, step_up, step_down,
//             |     |                  | step_accel, btn_*
// csr_*       | in  | write enable     | csr_index, csr_wdata
//
// One request per cycle unless the result register stalls; a taken request passes through
// the input register, then the result register fed by the encoder and button logic.
// Encoder and button state update in the cycle a request moves into the result register.
// A stalled result holds; one further request waits in the input register.
// Synchronous reset clears the valid flags and the encoder and button state and loads the register defaults at once.
`timescale 1ns / 1ps
`include "encoder_bank_with_button_debounce_defines.svh"

module encoder_bank_with_button_debounce import ebbd_pkg::*; #(
   parameter int NUM_ENCODERS = DEF_NUM_ENCODERS,
   parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   ebbd_req_if.sink                   req_chan,
   ebbd_rsp_if.source                 rsp_chan
);

   localparam int SEL_WIDTH = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
   localparam int NUM_LINES = LINES_PER_ENC * NUM_ENCODERS;

   // configuration registers
   ms_type                  debounce_ms_ff;
   logic [PERIOD_WIDTH-1:0] long_press_ff;
   ebbd_accel_type          accel_ff;
   logic [NUM_ENCODERS-1:0] invert_mask_ff;

   // input stage
   logic                    in_valid_ff, in_valid_in;
   logic                    req_type_ff;
   logic [NUM_LINES-1:0]    line_ff;
   ms_type                  elapsed_ff;
   logic [SEL_WIDTH-1:0]    sel_ff;
   logic                    clear_ff;

   // result stage
   logic                                out_valid_ff, out_valid_in;
   logic signed [COUNT_VALUE_WIDTH-1:0] count_value_ff;
   logic [NUM_ENCODERS-1:0] enc_changed_ff, step_up_ff, step_down_ff, step_accel_ff;
   logic [NUM_ENCODERS-1:0] btn_current_ff, btn_toggled_ff, btn_activated_ff;
   logic [NUM_ENCODERS-1:0] btn_short_ff, btn_long_ff, btn_changed_ff;

   logic                    advance;
   logic                    req_take;
   ebbd_ctl_type            ctl;
   logic [NUM_ENCODERS-1:0] a_lines, b_lines, sw_lines;
   logic [COUNT_WIDTH-1:0]  count_out;
   logic [COUNT_WIDTH+COUNT_VALUE_WIDTH-1:0] count_wide;
   logic [NUM_ENCODERS-1:0] enc_changed, step_up, step_down, step_accel;
   logic [NUM_ENCODERS-1:0] btn_current, btn_toggled, btn_activated;
   logic [NUM_ENCODERS-1:0] btn_short, btn_long, btn_changed;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff  <= RST_DEBOUNCE_MS;
         long_press_ff   <= RST_LONG_PRESS;
         accel_ff.vf_thr  <= RST_VF_THRESHOLD;
         accel_ff.vf_step <= RST_VF_STEP;
         accel_ff.f_thr   <= RST_F_THRESHOLD;
         accel_ff.f_step  <= RST_F_STEP;
         invert_mask_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS:  debounce_ms_ff   <= csr_wdata[MS_WIDTH-1:0];
            CSR_LONG_PRESS:   long_press_ff    <= csr_wdata[PERIOD_WIDTH-1:0];
            CSR_VF_THRESHOLD: accel_ff.vf_thr  <= csr_wdata[MS_WIDTH-1:0];
            CSR_VF_STEP:      accel_ff.vf_step <= csr_wdata[STEP_WIDTH-1:0];
            CSR_F_THRESHOLD:  accel_ff.f_thr   <= csr_wdata[MS_WIDTH-1:0];
            CSR_F_STEP:       accel_ff.f_step  <= csr_wdata[STEP_WIDTH-1:0];
            CSR_INVERT_MASK:  invert_mask_ff   <= csr_wdata[NUM_ENCODERS-1:0];
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // move the held request on whenever the result register is free or draining
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_take || (in_valid_ff && !advance);
   assign out_valid_in   = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_type_ff <= req_chan.req_type;
         line_ff     <= req_chan.line_vector;
         elapsed_ff  <= req_chan.elapsed_ms;
         sel_ff      <= req_chan.encoder_select;
         clear_ff    <= req_chan.clear_count;
      end
   end

   always_comb begin
      ctl.tick  = advance && (req_type_ff == REQ_TICK);
      ctl.rd    = advance && (req_type_ff == REQ_READ);
      ctl.clear = clear_ff;
      for (int i = 0; i < NUM_ENCODERS; i++) begin
         a_lines[i]  = line_ff[LINES_PER_ENC*i + LINE_A];
         b_lines[i]  = line_ff[LINES_PER_ENC*i + LINE_B];
         sw_lines[i] = line_ff[LINES_PER_ENC*i + LINE_SW];
      end
   end

   ebbd_encoders #(
      .NUM_ENCODERS (NUM_ENCODERS),
      .COUNT_WIDTH  (COUNT_WIDTH),
      .SEL_WIDTH    (SEL_WIDTH)
   ) u_encoders (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .a_lines        (a_lines),
      .b_lines        (b_lines),
      .elapsed_ms     (elapsed_ff),
      .encoder_select (sel_ff),
      .accel          (accel_ff),
      .invert_mask    (invert_mask_ff),
      .count_out      (count_out),
      .enc_changed    (enc_changed),
      .step_up        (step_up),
      .step_down      (step_down),
      .step_accel     (step_accel)
   );

   ebbd_buttons #(
      .NUM_ENCODERS (NUM_ENCODERS)
   ) u_buttons (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sw_lines           (sw_lines),
      .elapsed_ms         (elapsed_ff),
      .debounce_ms        (debounce_ms_ff),
      .long_press_periods (long_press_ff),
      .btn_current        (btn_current),
      .btn_toggled        (btn_toggled),
      .btn_activated      (btn_activated),
      .btn_short          (btn_short),
      .btn_long           (btn_long),
      .btn_changed        (btn_changed)
   );

   // count is reported as its low bits, zero-filled when narrower
   assign count_wide = {{COUNT_VALUE_WIDTH{1'b0}}, count_out};

   always_ff @(posedge clock) begin
      if (advance) begin
         count_value_ff   <= count_wide[COUNT_VALUE_WIDTH-1:0];
         enc_changed_ff   <= enc_changed;
         step_up_ff       <= step_up;
         step_down_ff     <= step_down;
         step_accel_ff    <= step_accel;
         btn_current_ff   <= btn_current;
         btn_toggled_ff   <= btn_toggled;
         btn_activated_ff <= btn_activated;
         btn_short_ff     <= btn_short;
         btn_long_ff      <= btn_long;
         btn_changed_ff   <= btn_changed;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.count_value   = count_value_ff;
   assign rsp_chan.enc_changed   = enc_changed_ff;
   assign rsp_chan.step_up       = step_up_ff;
   assign rsp_chan.step_down     = step_down_ff;
   assign rsp_chan.step_accel    = step_accel_ff;
   assign rsp_chan.btn_current   = btn_current_ff;
   assign rsp_chan.btn_toggled   = btn_toggled_ff;
   assign rsp_chan.btn_activated = btn_activated_ff;
   assign rsp_chan.btn_short     = btn_short_ff;
   assign rsp_chan.btn_long      = btn_long_ff;
   assign rsp_chan.btn_changed   = btn_changed_ff;

   `EBBD_ASSERT_NEXT(a_take_fills_stage, clock, reset, req_take, in_valid_ff,
      "accepted request did not reach the input register")
   `EBBD_ASSERT_NEXT(a_advance_fills_result, clock, reset, advance, out_valid_ff,
      "processed request did not reach the result register")
   `EBBD_ASSERT_NOW(a_no_up_and_down, clock, reset, out_valid_ff,
      (step_up_ff & step_down_ff) == '0, "encoder stepped up and down together")
   `EBBD_ASSERT_NEXT(a_read_no_steps, clock, reset, ctl.rd,
      (step_up_ff | step_down_ff | step_accel_ff) == '0, "read result reports steps")

endmodule

// ===== bench/ebbd_result_checker.sv =====
// Result checker for the encoder bank: predicts every result from the requests
// and register writes it observes, and compares them in order with the results.
// Depends on ebbd_pkg and the channel interfaces in ebbd_if.
`timescale 1ns / 1ps

module ebbd_result_checker import ebbd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   ebbd_req_if                        req_mon,
   ebbd_rsp_if                        rsp_mon,
   output int                         error_count,
   output int                         pending_count
);

   localparam int NENC  = DEF_NUM_ENCODERS;
   localparam int SELW  = (NENC > 1) ? $clog2(NENC) : 1;
   localparam int LINES = LINES_PER_ENC * NENC;

   typedef struct packed {
      logic signed [COUNT_VALUE_WIDTH-1:0] count_value;
      logic [NENC-1:0]                     enc_changed;
      logic [NENC-1:0]                     step_up;
      logic [NENC-1:0]                     step_down;
      logic [NENC-1:0]                     step_accel;
      logic [NENC-1:0]                     btn_current;
      logic [NENC-1:0]                     btn_toggled;
      logic [NENC-1:0]                     btn_activated;
      logic [NENC-1:0]                     btn_short;
      logic [NENC-1:0]                     btn_long;
      logic [NENC-1:0]                     btn_changed;
   } bank_result_type;

   // register copies
   logic [MS_WIDTH-1:0]     debounce_ms;
   logic [PERIOD_WIDTH-1:0] long_press_periods;
   logic [MS_WIDTH-1:0]     vf_thr;
   logic [STEP_WIDTH-1:0]   vf_step;
   logic [MS_WIDTH-1:0]     f_thr;
   logic [STEP_WIDTH-1:0]   f_step;
   logic [NENC-1:0]         invert_mask;

   // bank state
   logic [NENC-1:0]              prev_a;
   logic [NENC-1:0]              prev_raw;
   logic [MS_WIDTH-1:0]          deb_timer;
   logic [NENC-1:0]              stable_sw;
   logic [PERIOD_WIDTH-1:0]      lp_timer;
   logic [NENC-1:0]              lp_pattern;
   logic [COUNT_VALUE_WIDTH-1:0] counts [NENC];
   logic [NENC-1:0]              moved;
   logic [NENC-1:0]              sw_changed;
   logic [NENC-1:0]              sw_activated;
   logic [NENC-1:0]              sw_toggled;
   logic [NENC-1:0]              sw_short;
   logic [NENC-1:0]              sw_long;

   bank_result_type expected_results [$];
   int              mismatches = 0;

   assign error_count = mismatches;

   function automatic bank_result_type predict_bank_result(
      input logic              kind,
      input logic [LINES-1:0]  lines,
      input logic [MS_WIDTH-1:0] ms,
      input logic [SELW-1:0]   sel,
      input logic              clr
   );
      bank_result_type         r;
      logic [NENC-1:0]         a, b, s, act, dif, pressed, released;
      logic [STEP_WIDTH-1:0]   step;
      int                      e;
      r = '0;
      if (kind == REQ_TICK) begin
         for (e = 0; e < NENC; e++) begin
            a[e] = lines[LINES_PER_ENC*e + LINE_A];
            b[e] = lines[LINES_PER_ENC*e + LINE_B];
            s[e] = lines[LINES_PER_ENC*e + LINE_SW];
         end
         if (a != prev_a) begin
            act = (a ^ invert_mask) & (a ^ prev_a);
            step = (ms < vf_thr) ? vf_step : ((ms < f_thr) ? f_step : STEP_WIDTH'(1));
            r.step_up   = act & ~b;
            r.step_down = act & b;
            prev_a = a;
            for (e = 0; e < NENC; e++) begin
               if (r.step_up[e])
                  counts[e] = counts[e] + COUNT_VALUE_WIDTH'(step);
               else if (r.step_down[e])
                  counts[e] = counts[e] - COUNT_VALUE_WIDTH'(step);
            end
            moved |= r.step_up | r.step_down;
            if (step > STEP_WIDTH'(1))
               r.step_accel = r.step_up | r.step_down;
         end
         if (s == prev_raw) begin
            deb_timer = (deb_timer > ms) ? deb_timer - ms : '0;
         end else begin
            deb_timer = debounce_ms;
            prev_raw = s;
         end
         // accept the switch pattern once it has held for the debounce period
         if (deb_timer == '0) begin
            deb_timer = debounce_ms;
            dif = s ^ stable_sw;
            pressed = dif & s;
            released = dif & stable_sw;
            sw_changed |= dif;
            sw_activated = (sw_activated | pressed) & ~released;
            sw_toggled ^= pressed;
            stable_sw = s;
            if (dif != '0) begin
               lp_timer = long_press_periods;
               sw_short = (sw_short | (released & ~lp_pattern)) & ~pressed;
               sw_long &= ~released;
               lp_pattern &= ~released;
            end else if (lp_timer > '0) begin
               lp_timer--;
               if (lp_timer == '0) begin
                  lp_pattern = s;
                  sw_long |= s;
                  sw_short &= ~s;
               end
            end
         end
         r.enc_changed = moved;
         r.btn_changed = sw_changed;
      end else begin
         r.enc_changed = moved;
         r.btn_changed = sw_changed;
         if (int'(sel) < NENC) begin
            r.count_value = counts[sel];
            if (clr)
               counts[sel] = '0;
            moved[sel] = 1'b0;
         end
         sw_changed = '0;
      end
      r.btn_current   = stable_sw;
      r.btn_toggled   = sw_toggled;
      r.btn_activated = sw_activated;
      r.btn_short     = sw_short;
      r.btn_long      = sw_long;
      return r;
   endfunction

   task automatic check_field(input string field, input int want, input int got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      bank_result_type oldest;
      if (reset) begin
         debounce_ms        = RST_DEBOUNCE_MS;
         long_press_periods = RST_LONG_PRESS;
         vf_thr             = RST_VF_THRESHOLD;
         vf_step            = RST_VF_STEP;
         f_thr              = RST_F_THRESHOLD;
         f_step             = RST_F_STEP;
         invert_mask        = '0;
         prev_a             = '0;
         prev_raw           = '0;
         deb_timer          = RST_DEBOUNCE_MS;
         stable_sw          = '0;
         lp_timer           = RST_LONG_PRESS;
         lp_pattern         = '0;
         for (int e = 0; e < NENC; e++)
            counts[e] = '0;
         moved              = '0;
         sw_changed         = '0;
         sw_activated       = '0;
         sw_toggled         = '0;
         sw_short           = '0;
         sw_long            = '0;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEBOUNCE_MS:  debounce_ms        = csr_wdata[MS_WIDTH-1:0];
               CSR_LONG_PRESS:   long_press_periods = csr_wdata[PERIOD_WIDTH-1:0];
               CSR_VF_THRESHOLD: vf_thr             = csr_wdata[MS_WIDTH-1:0];
               CSR_VF_STEP:      vf_step            = csr_wdata[STEP_WIDTH-1:0];
               CSR_F_THRESHOLD:  f_thr              = csr_wdata[MS_WIDTH-1:0];
               CSR_F_STEP:       f_step             = csr_wdata[STEP_WIDTH-1:0];
               CSR_INVERT_MASK:  invert_mask        = csr_wdata[NENC-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("result arrived with no request outstanding");
               mismatches++;
            end else begin
               oldest = expected_results.pop_front();
               check_field("count_value", int'(oldest.count_value),
                           int'(rsp_mon.count_value));
               check_field("enc_changed", int'(oldest.enc_changed),
                           int'(rsp_mon.enc_changed));
               check_field("step_up", int'(oldest.step_up), int'(rsp_mon.step_up));
               check_field("step_down", int'(oldest.step_down), int'(rsp_mon.step_down));
               check_field("step_accel", int'(oldest.step_accel),
                           int'(rsp_mon.step_accel));
               check_field("btn_current", int'(oldest.btn_current),
                           int'(rsp_mon.btn_current));
               check_field("btn_toggled", int'(oldest.btn_toggled),
                           int'(rsp_mon.btn_toggled));
               check_field("btn_activated", int'(oldest.btn_activated),
                           int'(rsp_mon.btn_activated));
               check_field("btn_short", int'(oldest.btn_short), int'(rsp_mon.btn_short));
               check_field("btn_long", int'(oldest.btn_long), int'(rsp_mon.btn_long));
               check_field("btn_changed", int'(oldest.btn_changed),
                           int'(rsp_mon.btn_changed));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(predict_bank_result(req_mon.req_type,
               req_mon.line_vector, req_mon.elapsed_ms, req_mon.encoder_select,
               req_mon.clear_count));
      end
      pending_count = expected_results.size();
   end

endmodule

// ===== bench/encoder_bank_with_button_debounce_test.sv =====
// Top of the encoder bank testbench: clock, reset, register settings and request
// stimulus with random idling on both channels; the result checker gives the verdict.
// Depends on ebbd_pkg, ebbd_if, the encoder bank RTL and ebbd_result_checker.
`timescale 1ns / 1ps

module encoder_bank_with_button_debounce_test;
   import ebbd_pkg::*;

   localparam int NENC = DEF_NUM_ENCODERS;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;
   int                         bank_errors;
   int                         bank_pending;

   logic                       idle_on = 1'b1;
   int                         ticks_sent = 0;
   int                         reads_sent = 0;
   int                         settings_used = 0;

   // stimulus-side view of the encoder lines
   logic [1:0]                 quad [NENC];
   logic [NENC-1:0]            spin_dir;
   logic [NENC-1:0]            sw_raw;
   logic [NENC-1:0]            bounce_back;

   ebbd_req_if req_chan ();
   ebbd_rsp_if rsp_chan ();

   encoder_bank_with_button_debounce u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   ebbd_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .error_count   (bank_errors),
      .pending_count (bank_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("DONE: errors detected");
      $finish;
   end

   // result side: stall in random bursts while idling is on
   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 9) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic kind, input logic [8:0] lines,
                               input logic [MS_WIDTH-1:0] ms, input logic [1:0] sel,
                               input logic clr);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.req_type       <= kind;
      req_chan.line_vector    <= lines;
      req_chan.elapsed_ms     <= ms;
      req_chan.encoder_select <= sel;
      req_chan.clear_count    <= clr;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (kind == REQ_TICK)
         ticks_sent++;
      else
         reads_sent++;
   endtask

   // drop valid and hold until every result is back
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (bank_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_WIDTH-1:0];
      @(posedge clock);
   endtask

   task automatic apply_settings(input int deb, input int lp, input int vft, input int vfs,
                                 input int ft, input int fs, input int inv);
      wait_idle();
      write_csr(CSR_DEBOUNCE_MS, deb);
      write_csr(CSR_LONG_PRESS, lp);
      write_csr(CSR_VF_THRESHOLD, vft);
      write_csr(CSR_VF_STEP, vfs);
      write_csr(CSR_F_THRESHOLD, ft);
      write_csr(CSR_F_STEP, fs);
      write_csr(CSR_INVERT_MASK, inv);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // mostly clean quadrature motion and switch presses, with bounces and line noise
   task automatic run_phase(input int n_items);
      int                  i, e, sw_rate;
      logic [8:0]          lines;
      logic [MS_WIDTH-1:0] ms;
      sw_rate = $urandom_range(4, 24);
      for (i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 5) == 0) begin
            send_request(REQ_READ, 9'($urandom), MS_WIDTH'($urandom),
                         2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         end else begin
            for (e = 0; e < NENC; e++) begin
               if ($urandom_range(0, 2) == 0) begin
                  if ($urandom_range(0, 15) == 0)
                     spin_dir[e] = ~spin_dir[e];
                  quad[e] = spin_dir[e] ? quad[e] - 2'd1 : quad[e] + 2'd1;
               end
            end
            sw_raw ^= bounce_back;
            bounce_back = '0;
            if ($urandom_range(1, sw_rate) == 1) begin
               e = $urandom_range(0, NENC - 1);
               sw_raw[e] = ~sw_raw[e];
               if ($urandom_range(0, 3) == 0)
                  bounce_back[e] = 1'b1;
            end
            for (e = 0; e < NENC; e++) begin
               lines[LINES_PER_ENC*e + LINE_A]  = quad[e][0] ^ quad[e][1];
               lines[LINES_PER_ENC*e + LINE_B]  = quad[e][1];
               lines[LINES_PER_ENC*e + LINE_SW] = sw_raw[e];
            end
            if ($urandom_range(0, 19) == 0)
               lines = 9'($urandom);
            case ($urandom_range(0, 5))
               0:       ms = MS_WIDTH'($urandom_range(0, 255));
               1:       ms = MS_WIDTH'($urandom_range(0, 12));
               2:       ms = MS_WIDTH'($urandom_range(1, 40));
               default: ms = MS_WIDTH'($urandom_range(1, 6));
            endcase
            send_request(REQ_TICK, lines, ms, 2'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      reset                   <= 1'b1;
      csr_we                  <= 1'b0;
      csr_index               <= CSR_DEBOUNCE_MS;
      csr_wdata               <= '0;
      req_chan.valid          <= 1'b0;
      req_chan.req_type       <= REQ_TICK;
      req_chan.line_vector    <= '0;
      req_chan.elapsed_ms     <= '0;
      req_chan.encoder_select <= '0;
      req_chan.clear_count    <= 1'b0;
      for (int e = 0; e < NENC; e++)
         quad[e] = 2'd0;
      spin_dir    = '0;
      sw_raw      = '0;
      bounce_back = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: empty reads, bad select, wrapping down step, zero elapsed,
      // debounced press and release, very fast and fast steps
      send_request(REQ_READ, 9'h000, 8'd0, 2'd0, 1'b0);
      send_request(REQ_READ, 9'h000, 8'd0, 2'd3, 1'b1);
      send_request(REQ_TICK, 9'h000, 8'd255, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h1FF, 8'd255, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h1FF, 8'd0, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h1FF, 8'd20, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h000, 8'd5, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h049, 8'd5, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h000, 8'd15, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h049, 8'd15, 2'd0, 1'b0);
      send_request(REQ_READ, 9'h1FF, 8'd255, 2'd0, 1'b0);
      send_request(REQ_READ, 9'h000, 8'd0, 2'd1, 1'b1);
      send_request(REQ_READ, 9'h000, 8'd0, 2'd2, 1'b0);
      send_request(REQ_READ, 9'h000, 8'd0, 2'd1, 1'b0);

      // no debounce, no long press, zero very fast step, inverted A lines
      apply_settings(0, 0, 255, 0, 255, 255, 7);
      send_request(REQ_TICK, 9'h1FF, 8'd1, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h000, 8'd1, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h1FF, 8'd1, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h1FF, 8'd1, 2'd0, 1'b0);

      // short debounce and long press after two periods; step always one
      apply_settings(1, 2, 0, 255, 0, 255, 0);
      send_request(REQ_TICK, 9'h004, 8'd1, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h004, 8'd1, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h004, 8'd1, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h004, 8'd1, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h000, 8'd1, 2'd0, 1'b0);
      send_request(REQ_TICK, 9'h000, 8'd1, 2'd0, 1'b0);
      send_request(REQ_READ, 9'h000, 8'd1, 2'd3, 1'b0);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: apply_settings(int'(RST_DEBOUNCE_MS), int'(RST_LONG_PRESS),
                              int'(RST_VF_THRESHOLD), int'(RST_VF_STEP),
                              int'(RST_F_THRESHOLD), int'(RST_F_STEP), 0);
            1: apply_settings(1, 1, 255, 255, 255, 255, 7);
            2: apply_settings(255, 65535, 0, 1, 0, 1, 5);
            3: apply_settings(2, 3, 40, 3, 120, 2, 2);
            6: apply_settings(0, 0, 128, 0, 200, 200, 1);
            default: apply_settings($urandom_range(1, 12), $urandom_range(1, 6),
                                    $urandom_range(0, 20), $urandom_range(1, 255),
                                    $urandom_range(0, 60), $urandom_range(1, 255),
                                    $urandom_range(0, 7));
         endcase
         // run the final stretch at full rate
         if (p == 7)
            idle_on = 1'b0;
         run_phase(144);
      end

      wait_idle();
      $display("Sent %0d ticks and %0d reads under %0d register settings",
               ticks_sent, reads_sent, settings_used + 1);
      if (bank_errors == 0 && bank_pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
